/* sv/cda_pkg.sv */
package cda_pkg;

    localparam int YEAR_W        = 14;
    localparam int MONTH_W       = 4;
    localparam int DAY_W         = 5;
    localparam int COUNT_FIELD_W = 16;
    localparam int QUO_W         = 8;
    localparam int REM100_W      = 7;

    localparam int YEAR_LIMIT_DEF = 9999;
    localparam int COUNT_BITS_DEF = 16;

    // year / 100 as (year * 5243) >> 19, exact for 14-bit years
    localparam int DIV100_MUL_W = 13;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PROD_W = YEAR_W + DIV100_MUL_W;

    localparam logic [YEAR_W-1:0]   CENTURY     = 14'd100;
    localparam logic [MONTH_W-1:0]  MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
    localparam logic [DAY_W-1:0]    DAY_DEC_END = 5'd31;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [QUO_W-1:0]    quo;     // year / 100
        logic [REM100_W-1:0] rem100;  // year % 100
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } date_t;

    function automatic logic is_leap(input logic [QUO_W-1:0] quo,
                                     input logic [REM100_W-1:0] rem100);
        logic by4;
        by4 = (rem100[1:0] == 2'd0);
        return by4 && ((rem100 != '0) || (quo[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* sv/cda_step.sv */
module cda_step
    import cda_pkg::*;
#(
    parameter int YEAR_LIMIT = YEAR_LIMIT_DEF,
    parameter int CNT_W      = COUNT_BITS_DEF
) (
    input  date_t              cur,
    input  logic [CNT_W-1:0]   rem,
    output date_t              nxt,
    output logic [CNT_W-1:0]   rem_next,
    output logic [DAY_W-1:0]   len,
    output logic               ovf
);

    logic             leap;
    logic [CNT_W:0]   end_day;
    logic             fits;
    logic [DAY_W-1:0] consumed;

    always_comb begin
        leap     = is_leap(cur.quo, cur.rem100);
        len      = month_len(cur.month, leap);
        end_day  = (CNT_W+1)'(cur.day) + (CNT_W+1)'(rem);
        fits     = (end_day <= (CNT_W+1)'(len));
        consumed = len - cur.day + DAY_FIRST;

        nxt      = cur;
        rem_next = '0;
        ovf      = 1'b0;
        if (fits) begin
            nxt.day = end_day[DAY_W-1:0];
        end else begin
            rem_next  = rem - CNT_W'(consumed);
            nxt.day   = DAY_FIRST;
            nxt.month = cur.month + MONTH_JAN;
            if (cur.month == MONTH_DEC) begin
                nxt.month = MONTH_JAN;
                if (cur.year >= YEAR_W'(YEAR_LIMIT)) begin
                    nxt.month = MONTH_DEC;
                    nxt.day   = DAY_DEC_END;
                    rem_next  = '0;
                    ovf       = 1'b1;
                end else begin
                    nxt.year = cur.year + YEAR_W'(1);
                    if (cur.rem100 == REM100_W'(99)) begin
                        nxt.rem100 = '0;
                        nxt.quo    = cur.quo + QUO_W'(1);
                    end else begin
                        nxt.rem100 = cur.rem100 + REM100_W'(1);
                    end
                end
            end
        end
    end

endmodule

/* sv/calendar_day_adder_top.sv */
// channel | ports                       | content
// input   | s_tvalid s_tready s_tdata   | tdata: load_year, load_month, load_day, day_count
//         | s_tuser                     | tuser: operation
// result  | m_tvalid m_tready m_tdata   | tdata: out_year, out_month, out_day
//         | m_tuser                     | tuser: overflow
// Load passes from accept through LDIV (divide-by-100 multiply), LREM (remainder),
// LFIN (day clamp) and DONE (output) to the result register. Add walks in ST_WALK one
// month per step of the shared step unit (the last, partial month included), up to
// about 2160 month steps for the largest count. One item at a time; s_tready is high
// only while idle. A held result does not block the next item, only the writing of the
// next result. Reset (synchronous, aresetn low) gives date 0001-01-01.
module calendar_day_adder_top
    import cda_pkg::*;
#(
    parameter int YEAR_LIMIT = YEAR_LIMIT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // load_year, load_month, load_day, day_count, pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_year, out_month, out_day, pad
    output logic        m_tuser    // overflow
);

    localparam int CNT_W = (COUNT_BITS < COUNT_FIELD_W) ? COUNT_BITS : COUNT_FIELD_W;
    localparam int IN_MONTH_LSB = YEAR_W;
    localparam int IN_DAY_LSB   = IN_MONTH_LSB + MONTH_W;
    localparam int IN_CNT_LSB   = IN_DAY_LSB + DAY_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LDIV = 6'b000010,
        ST_LREM = 6'b000100,
        ST_LFIN = 6'b001000,
        ST_WALK = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    date_t             cur_reg, cur_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              ovf_reg, ovf_next;
    logic              m_valid_reg, m_valid_next;
    logic [23:0]       m_data_reg, m_data_next;
    logic              m_user_reg, m_user_next;

    date_t             step_nxt;
    logic [CNT_W-1:0]  step_rem;
    logic [DAY_W-1:0]  step_len;
    logic              step_ovf;

    logic [YEAR_W-1:0]        in_year;
    logic [MONTH_W-1:0]       in_month;
    logic [DAY_W-1:0]         in_day;
    logic [DIV100_PROD_W-1:0] div_prod;
    logic [YEAR_W-1:0]        cent_part;

    cda_step #(
        .YEAR_LIMIT (YEAR_LIMIT),
        .CNT_W      (CNT_W)
    ) u_step (
        .cur      (cur_reg),
        .rem      (rem_reg),
        .nxt      (step_nxt),
        .rem_next (step_rem),
        .len      (step_len),
        .ovf      (step_ovf)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        in_year   = s_tdata[YEAR_W-1:0];
        in_month  = s_tdata[IN_MONTH_LSB +: MONTH_W];
        in_day    = s_tdata[IN_DAY_LSB +: DAY_W];
        div_prod  = DIV100_PROD_W'(cur_reg.year) * DIV100_PROD_W'(DIV100_MUL);
        cent_part = YEAR_W'(cur_reg.quo) * CENTURY;

        state_next   = state_reg;
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ovf_next = 1'b0;
                    if (s_tuser == OP_LOAD) begin
                        cur_next.year = in_year;
                        if (in_year == '0) begin
                            cur_next.year = YEAR_W'(1);
                        end else if (in_year > YEAR_W'(YEAR_LIMIT)) begin
                            cur_next.year = YEAR_W'(YEAR_LIMIT);
                        end
                        cur_next.month = in_month;
                        if (in_month == '0) begin
                            cur_next.month = MONTH_JAN;
                        end else if (in_month > MONTH_DEC) begin
                            cur_next.month = MONTH_DEC;
                        end
                        cur_next.day = (in_day == '0) ? DAY_FIRST : in_day;
                        rem_next     = '0;
                        state_next   = ST_LDIV;
                    end else begin
                        rem_next   = s_tdata[IN_CNT_LSB +: CNT_W];
                        state_next = ST_WALK;
                    end
                end
            end
            ST_LDIV: begin
                cur_next.quo = div_prod[DIV100_SHIFT +: QUO_W];
                state_next   = ST_LREM;
            end
            ST_LREM: begin
                cur_next.rem100 = REM100_W'(cur_reg.year - cent_part);
                state_next      = ST_LFIN;
            end
            ST_LFIN: begin
                if (cur_reg.day > step_len) begin
                    cur_next.day = step_len;
                end
                state_next = ST_DONE;
            end
            ST_WALK: begin
                if (rem_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cur_next = step_nxt;
                    rem_next = step_rem;
                    if (step_ovf) begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, cur_reg.day, cur_reg.month, cur_reg.year};
                    m_user_next  = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_reg.year   <= YEAR_W'(1);
            cur_reg.quo    <= '0;
            cur_reg.rem100 <= REM100_W'(1);
            cur_reg.month  <= MONTH_JAN;
            cur_reg.day    <= DAY_FIRST;
            rem_reg        <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            rem_reg     <= rem_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule
